FILE: design/mleu_pkg.sv
// Package for the MIPS-like execute unit: operation codes, FSM states,
// controller/datapath command and status structs. No dependencies.
package mleu_pkg;

   localparam int DataWidth   = 32;
   localparam int CmdWidth    = 5;
   localparam int IndexWidth  = 5;
   localparam int NumRegsDflt = 32;

   typedef enum logic [CmdWidth-1:0] {
      OP_ADD      = 5'd0,
      OP_SUB      = 5'd1,
      OP_ADDI     = 5'd2,
      OP_ADDI_UNS = 5'd3,
      OP_MUL      = 5'd4,
      OP_AND      = 5'd5,
      OP_OR       = 5'd6,
      OP_XOR      = 5'd7,
      OP_SLL      = 5'd8,
      OP_SRL      = 5'd9,
      OP_LI       = 5'd10,
      OP_ADDU     = 5'd11,
      OP_SUBU     = 5'd12,
      OP_ANDI     = 5'd13,
      OP_ORI      = 5'd14,
      OP_MULT     = 5'd15,
      OP_DIV      = 5'd16,
      OP_MOVE     = 5'd17,
      OP_MFHI     = 5'd18,
      OP_MFLO     = 5'd19
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_DONE,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;  // write zero at clear pointer
      logic load;        // capture input word
      logic read;        // register operand reads
      logic exec;        // register ALU result
      logic mul_start;
      logic mul_step;    // accumulate one partial product
      logic div_start;
      logic div_step;    // one quotient bit
      logic commit;      // write back and form result word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic is_mul;      // mul or mult
      logic is_div;
      logic div_zero;
      logic mul_last;
      logic div_last;
   } status_type;

endpackage

FILE: design/mleu_req_if.sv
// Valid/ready channel interfaces for the execute unit.
// Depends on mleu_pkg for widths.
interface mleu_req_if;
   import mleu_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CmdWidth-1:0]   cmd;
   logic [IndexWidth-1:0] dest_index;
   logic [IndexWidth-1:0] src_a_index;
   logic [IndexWidth-1:0] src_b_index;
   logic [DataWidth-1:0]  immediate;
   modport source (output valid, cmd, dest_index, src_a_index, src_b_index, immediate,
                   input ready);
   modport sink   (input valid, cmd, dest_index, src_a_index, src_b_index, immediate,
                   output ready);
endinterface

interface mleu_rsp_if;
   import mleu_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  write_enable;
   logic [IndexWidth-1:0] write_index;
   logic [DataWidth-1:0]  write_value;
   logic [DataWidth-1:0]  hi_value;
   logic [DataWidth-1:0]  lo_value;
   logic                  div_by_zero;
   modport source (output valid, write_enable, write_index, write_value, hi_value,
                   lo_value, div_by_zero, input ready);
   modport sink   (input valid, write_enable, write_index, write_value, hi_value,
                   lo_value, div_by_zero, output ready);
endinterface

FILE: design/mleu_ctrl.sv
// Controller FSM of the execute unit: sequences clear, read, execute,
// multiply and divide steps, and the word handshakes. Depends on mleu_pkg.
module mleu_ctrl
   import mleu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    ctl
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ctl.read = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.is_mul) begin
               ctl.mul_start = 1'b1;
               state_in      = ST_MUL;
            end else if (status.is_div && !status.div_zero) begin
               ctl.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               ctl.exec = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            ctl.mul_step = 1'b1;
            if (status.mul_last) state_in = ST_DONE;
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (status.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            ctl.commit = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("result word repeated");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while result pending");
   a_commit_then_out: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> rsp_valid)
      else $error("commit without result");

endmodule

FILE: design/mleu_dpath.sv
// Datapath of the execute unit: register file memory, HI/LO, ALU, a
// 4-step multiplier and a radix-2 divider. Depends on mleu_pkg.
module mleu_dpath
   import mleu_pkg::*;
#(
   parameter int NUM_REGS = NumRegsDflt
)(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               ctl,
   output status_type            status,
   input  logic [CmdWidth-1:0]   cmd,
   input  logic [IndexWidth-1:0] dest_index,
   input  logic [IndexWidth-1:0] src_a_index,
   input  logic [IndexWidth-1:0] src_b_index,
   input  logic [DataWidth-1:0]  immediate,
   output logic                  write_enable,
   output logic [IndexWidth-1:0] write_index,
   output logic [DataWidth-1:0]  write_value,
   output logic [DataWidth-1:0]  hi_value,
   output logic [DataWidth-1:0]  lo_value,
   output logic                  div_by_zero
);

   localparam int AddrW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int CntW   = AddrW + 1;
   localparam int DivCntW = $clog2(DataWidth);

   logic [DataWidth-1:0] mem [NUM_REGS];

   logic [CntW-1:0]       clr_ff;
   op_type                op_ff;
   logic [IndexWidth-1:0] rd_ff, ra_ff, rb_ff;
   logic [DataWidth-1:0]  imm_ff;
   logic [DataWidth-1:0]  a_ff, b_ff;
   logic [DataWidth-1:0]  hi_ff, lo_ff, val_ff;
   logic                  wr_ff, dz_ff;
   // multiplier: 16x16 partial products accumulated over 4 steps
   logic [1:0]            mcnt_ff;
   logic [2*DataWidth-1:0] prod_ff;
   // divider: restoring, one bit a step on magnitudes
   logic [DivCntW-1:0]    dcnt_ff;
   logic [DataWidth-1:0]  quo_ff, rem_ff, dvs_ff;
   logic                  na_ff, nb_ff;

   logic                  mem_we;
   logic [AddrW-1:0]      mem_wa;
   logic [DataWidth-1:0]  mem_wd;
   logic [DataWidth-1:0]  alu;
   logic                  wr_alu;
   logic                  rd_ok;
   logic [DataWidth:0]    rem_shift, rem_sub;
   logic [DataWidth-1:0]  quo_res, rem_res;
   logic [DataWidth/2-1:0] mx, my;
   logic [DataWidth-1:0]  pp;
   logic [2*DataWidth-1:0] pp_sh;

   assign rd_ok = (rd_ff != '0) && (int'(rd_ff) < NUM_REGS);

   // memory write port: clear sweep or commit
   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_ff[AddrW-1:0];
      mem_wd = '0;
      if (ctl.clear_step) begin
         mem_we = 1'b1;
      end else if (ctl.commit) begin
         mem_wa = AddrW'(rd_ff);
         if (op_ff == OP_MUL) begin
            mem_we = rd_ok;
            mem_wd = prod_ff[DataWidth-1:0];
         end else begin
            mem_we = wr_ff;
            mem_wd = val_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
   end

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end
   assign status.clear_done = (clr_ff == CntW'(NUM_REGS - 1));

   // combinational ALU
   always_comb begin
      alu    = '0;
      wr_alu = 1'b1;
      case (op_ff)
         OP_ADD, OP_ADDU:           alu = a_ff + b_ff;
         OP_SUB, OP_SUBU:           alu = a_ff - b_ff;
         OP_ADDI, OP_ADDI_UNS:      alu = a_ff + imm_ff;
         OP_AND:                    alu = a_ff & b_ff;
         OP_OR:                     alu = a_ff | b_ff;
         OP_XOR:                    alu = a_ff ^ b_ff;
         OP_SLL:                    alu = a_ff << imm_ff[4:0];
         OP_SRL:                    alu = a_ff >> imm_ff[4:0];
         OP_LI:                     alu = imm_ff;
         OP_ANDI:                   alu = a_ff & imm_ff;
         OP_ORI:                    alu = a_ff | imm_ff;
         OP_MOVE:                   alu = a_ff;
         OP_MFHI:                   alu = hi_ff;
         OP_MFLO:                   alu = lo_ff;
         default:                   wr_alu = 1'b0;
      endcase
   end

   assign status.is_mul   = (op_ff == OP_MUL) || (op_ff == OP_MULT);
   assign status.is_div   = (op_ff == OP_DIV);
   assign status.div_zero = (b_ff == '0);
   assign status.mul_last = (mcnt_ff == 2'd3);
   assign status.div_last = (dcnt_ff == '0);

   // partial product select: step k takes halves (k[0], k[1])
   always_comb begin
      mx    = mcnt_ff[0] ? a_ff[DataWidth-1:DataWidth/2] : a_ff[DataWidth/2-1:0];
      my    = mcnt_ff[1] ? b_ff[DataWidth-1:DataWidth/2] : b_ff[DataWidth/2-1:0];
      pp    = DataWidth'(mx) * DataWidth'(my);
      pp_sh = (2*DataWidth)'(pp) << (DataWidth/2 * (32'(mcnt_ff[0]) + 32'(mcnt_ff[1])));
   end

   // divider step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DataWidth-1]};
      rem_sub   = rem_shift - {1'b0, dvs_ff};
      quo_res   = (na_ff != nb_ff) ? (DataWidth'(0) - quo_ff) : quo_ff;
      rem_res   = na_ff ? (DataWidth'(0) - rem_ff) : rem_ff;
   end

   // operand, execute and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else begin
         if (ctl.load) begin
            op_ff  <= op_type'(cmd);
            rd_ff  <= dest_index;
            ra_ff  <= src_a_index;
            rb_ff  <= src_b_index;
            imm_ff <= immediate;
            dz_ff  <= 1'b0;
            wr_ff  <= 1'b0;
         end
         // operand read, out of range reads as zero
         if (ctl.read) begin
            a_ff <= (int'(ra_ff) < NUM_REGS) ? mem[AddrW'(ra_ff)] : '0;
            b_ff <= (int'(rb_ff) < NUM_REGS) ? mem[AddrW'(rb_ff)] : '0;
         end
         if (ctl.exec) begin
            wr_ff  <= wr_alu && rd_ok;
            val_ff <= alu;
            dz_ff  <= status.is_div;
         end
         if (ctl.mul_start) begin
            mcnt_ff <= '0;
            prod_ff <= '0;
         end
         if (ctl.mul_step) begin
            mcnt_ff <= mcnt_ff + 1'b1;
            prod_ff <= prod_ff + pp_sh;
         end
         if (ctl.div_start) begin
            na_ff   <= a_ff[DataWidth-1];
            nb_ff   <= b_ff[DataWidth-1];
            quo_ff  <= a_ff[DataWidth-1] ? (DataWidth'(0) - a_ff) : a_ff;
            dvs_ff  <= b_ff[DataWidth-1] ? (DataWidth'(0) - b_ff) : b_ff;
            rem_ff  <= '0;
            dcnt_ff <= DivCntW'(DataWidth - 1);
         end
         if (ctl.div_step) begin
            dcnt_ff <= dcnt_ff - 1'b1;
            if (!rem_sub[DataWidth]) begin
               rem_ff <= rem_sub[DataWidth-1:0];
               quo_ff <= {quo_ff[DataWidth-2:0], 1'b1};
            end else begin
               rem_ff <= rem_shift[DataWidth-1:0];
               quo_ff <= {quo_ff[DataWidth-2:0], 1'b0};
            end
         end
         if (ctl.commit) begin
            if (op_ff == OP_MULT) begin
               hi_ff <= prod_ff[2*DataWidth-1:DataWidth];
               lo_ff <= prod_ff[DataWidth-1:0];
            end else if (op_ff == OP_MUL) begin
               wr_ff  <= rd_ok;
               val_ff <= prod_ff[DataWidth-1:0];
            end else if (status.is_div && !dz_ff) begin
               hi_ff <= rem_res;
               lo_ff <= quo_res;
            end
         end
      end
   end

   // result word, held until taken
   always_comb begin
      write_enable = wr_ff;
      write_index  = wr_ff ? rd_ff : '0;
      write_value  = wr_ff ? val_ff : '0;
      hi_value     = hi_ff;
      lo_value     = lo_ff;
      div_by_zero  = dz_ff;
   end

   a_r0_never: assert property (@(posedge clock) disable iff (reset)
      (ctl.commit && rd_ff == '0) |=> !wr_ff)
      else $error("write to register zero");
   a_dz_keeps: assert property (@(posedge clock) disable iff (reset)
      (ctl.commit && dz_ff) |=> (hi_ff == $past(hi_ff) && lo_ff == $past(lo_ff)))
      else $error("divide by zero changed HI/LO");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      ctl.div_start |=> dcnt_ff == DivCntW'(DataWidth - 1))
      else $error("divider count not loaded");

endmodule

FILE: design/mips_like_execute_unit.sv
// Top level of the MIPS-like execute unit: controller plus datapath.
// Depends on mleu_pkg, mleu_req_if/mleu_rsp_if, mleu_ctrl, mleu_dpath.
//
// One instruction at a time. After reset a clearing pass writes zero to
// each register, with req_ready low. An ALU instruction goes from
// acceptance to result valid through register read, execute, commit;
// MUL and MULT add the four 16x16 partial product steps, and DIV with a
// nonzero divisor the 32 steps of the radix-2 divider.
// The result word is held until rsp_ready; the next word is accepted in
// the cycle after the result is taken.
module mips_like_execute_unit
   import mleu_pkg::*;
#(
   parameter int NUM_REGS = NumRegsDflt
)(
   input logic      clock,
   input logic      reset,
   mleu_req_if.sink req,
   mleu_rsp_if.source rsp
);

   cmd_type    ctl;
   status_type status;

   mleu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .ctl       (ctl)
   );

   mleu_dpath #(.NUM_REGS(NUM_REGS)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .status       (status),
      .cmd          (req.cmd),
      .dest_index   (req.dest_index),
      .src_a_index  (req.src_a_index),
      .src_b_index  (req.src_b_index),
      .immediate    (req.immediate),
      .write_enable (rsp.write_enable),
      .write_index  (rsp.write_index),
      .write_value  (rsp.write_value),
      .hi_value     (rsp.hi_value),
      .lo_value     (rsp.lo_value),
      .div_by_zero  (rsp.div_by_zero)
   );

endmodule

FILE: tb/sv/mips_like_execute_unit_checker.sv
`timescale 1ns / 1ps
// Checker for the MIPS-like execute unit: watches both channels, predicts each result word.
// Depends on mleu_pkg and the mleu_req_if / mleu_rsp_if interfaces.
module mips_like_execute_unit_checker
   import mleu_pkg::*;
#(
   parameter int NUM_REGS = NumRegsDflt
)(
   input  logic       clock,
   input  logic       reset,
   mleu_req_if        req,
   mleu_rsp_if        rsp,
   output int         fail_count,
   output int         pending_count,
   output int         result_count
);

   typedef struct packed {
      logic                  write_enable;
      logic [IndexWidth-1:0] write_index;
      logic [DataWidth-1:0]  write_value;
      logic [DataWidth-1:0]  hi_value;
      logic [DataWidth-1:0]  lo_value;
      logic                  div_by_zero;
   } effect_type;

   logic [DataWidth-1:0] model_regs [NUM_REGS];
   logic [DataWidth-1:0] model_hi, model_lo;
   effect_type           expected_effects [$];

   assign pending_count = expected_effects.size();

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic logic [DataWidth-1:0] read_model(input logic [IndexWidth-1:0] idx);
      return (idx < NUM_REGS) ? model_regs[idx] : '0;
   endfunction

   // Execute one instruction on the model state and return its effect.
   function automatic effect_type execute_instr(input logic [CmdWidth-1:0] cmd,
         input logic [IndexWidth-1:0] rd, input logic [IndexWidth-1:0] ra,
         input logic [IndexWidth-1:0] rb, input logic [DataWidth-1:0] imm);
      logic [DataWidth-1:0] a, b, val, ma, mb, q, r;
      logic [63:0]          prod;
      logic                 wr, dz, na, nb;
      effect_type           e;
      a = read_model(ra);
      b = read_model(rb);
      wr = 1'b1;
      dz = 1'b0;
      val = '0;
      case (cmd)
         OP_ADD, OP_ADDU:      val = a + b;
         OP_SUB, OP_SUBU:      val = a - b;
         OP_ADDI, OP_ADDI_UNS: val = a + imm;
         OP_MUL:               val = a * b;
         OP_AND:               val = a & b;
         OP_OR:                val = a | b;
         OP_XOR:               val = a ^ b;
         OP_SLL:               val = a << imm[4:0];
         OP_SRL:               val = a >> imm[4:0];
         OP_LI:                val = imm;
         OP_ANDI:              val = a & imm;
         OP_ORI:               val = a | imm;
         OP_MULT: begin
            prod = {32'd0, a} * {32'd0, b};
            model_hi = prod[63:32];
            model_lo = prod[31:0];
            wr = 1'b0;
         end
         OP_DIV: begin
            wr = 1'b0;
            if (b == '0) begin
               dz = 1'b1;
            end else begin
               na = a[31];
               nb = b[31];
               ma = na ? -a : a;
               mb = nb ? -b : b;
               q = ma / mb;
               r = ma % mb;
               model_lo = (na != nb) ? -q : q;
               model_hi = na ? -r : r;
            end
         end
         OP_MOVE:              val = a;
         OP_MFHI:              val = model_hi;
         OP_MFLO:              val = model_lo;
         default:              wr = 1'b0;
      endcase
      if (wr && (rd == '0 || rd >= NUM_REGS)) wr = 1'b0;
      if (wr) model_regs[rd] = val;
      e.write_enable = wr;
      e.write_index  = wr ? rd : '0;
      e.write_value  = wr ? val : '0;
      e.hi_value     = model_hi;
      e.lo_value     = model_lo;
      e.div_by_zero  = dz;
      return e;
   endfunction

   // Predict on each accepted instruction word, compare each accepted result word.
   always @(posedge clock) begin
      effect_type want;
      effect_type predicted;
      if (reset) begin
         foreach (model_regs[i]) model_regs[i] = '0;
         model_hi = '0;
         model_lo = '0;
         expected_effects.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (req.valid && req.ready) begin
            predicted = execute_instr(req.cmd, req.dest_index,
               req.src_a_index, req.src_b_index, req.immediate);
            expected_effects.insert(expected_effects.size(), predicted);
         end
         if (rsp.valid && rsp.ready) begin
            result_count++;
            if (expected_effects.size() == 0) begin
               report("unexpected result word", 64'd0, 64'd0);
            end else begin
               want = expected_effects.pop_front();
               if (rsp.write_enable !== want.write_enable)
                  report("write_enable", 64'(rsp.write_enable), 64'(want.write_enable));
               if (rsp.write_index !== want.write_index)
                  report("write_index", 64'(rsp.write_index), 64'(want.write_index));
               if (rsp.write_value !== want.write_value)
                  report("write_value", 64'(rsp.write_value), 64'(want.write_value));
               if (rsp.hi_value !== want.hi_value)
                  report("hi_value", 64'(rsp.hi_value), 64'(want.hi_value));
               if (rsp.lo_value !== want.lo_value)
                  report("lo_value", 64'(rsp.lo_value), 64'(want.lo_value));
               if (rsp.div_by_zero !== want.div_by_zero)
                  report("div_by_zero", 64'(rsp.div_by_zero), 64'(want.div_by_zero));
            end
         end
      end
   end

endmodule

FILE: tb/sv/mips_like_execute_unit_tb.sv
`timescale 1ns / 1ps
// Top of the execute unit testbench: clock, reset, instruction stimulus, verdict.
// Depends on mleu_pkg, the channel interfaces, the block and its checker.
module mips_like_execute_unit_tb;
   import mleu_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, result_count;
   int   sent_count = 0;

   mleu_req_if req ();
   mleu_rsp_if rsp ();

   mips_like_execute_unit u_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   mips_like_execute_unit_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Send one instruction word after a random gap, hold it until accepted.
   // Valid stays high after acceptance until the next gap or an explicit drop.
   task automatic send_instr(input logic [CmdWidth-1:0] cmd, input logic [4:0] rd,
         input logic [4:0] ra, input logic [4:0] rb, input logic [31:0] imm);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.cmd         <= cmd;
      req.dest_index  <= rd;
      req.src_a_index <= ra;
      req.src_b_index <= rb;
      req.immediate   <= imm;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      sent_count++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // Result side: random stall per word, with stretches of none.
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         @(negedge clock);
      end
   end

   initial begin
      logic [CmdWidth-1:0] cmd;
      req.valid = 1'b0;
      req.cmd = '0;
      req.dest_index = '0;
      req.src_a_index = '0;
      req.src_b_index = '0;
      req.immediate = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: load extremes, every operation, zero destination,
      // divide by zero, most negative over minus one, unused codes.
      send_instr(OP_LI, 5'd1, 5'd0, 5'd0, 32'h8000_0000);
      send_instr(OP_LI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF);
      send_instr(OP_LI, 5'd31, 5'd0, 5'd0, 32'h7FFF_FFFF);
      send_instr(OP_DIV, 5'd0, 5'd1, 5'd2, 32'h0);
      send_instr(OP_MFLO, 5'd3, 5'd0, 5'd0, 32'h0);
      send_instr(OP_MFHI, 5'd4, 5'd0, 5'd0, 32'h0);
      send_instr(OP_DIV, 5'd0, 5'd1, 5'd0, 32'h0);
      send_instr(OP_MULT, 5'd0, 5'd2, 5'd2, 32'h0);
      send_instr(OP_ADD, 5'd0, 5'd1, 5'd2, 32'h0);
      send_instr(OP_LI, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF);
      for (int op = 0; op <= 19; op++)
         send_instr(op[4:0], 5'd5 + op[4:0], 5'd2, 5'd31, 32'hFFFF_FFFF);
      send_instr(5'd20, 5'd6, 5'd1, 5'd2, 32'h1F);
      send_instr(5'd31, 5'd7, 5'd1, 5'd2, 32'h0);

      // Let the block drain once before the random part.
      req.valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);

      // Random: mostly valid codes, loads to seed registers, some unused codes.
      for (int n = 0; n < 1750; n++) begin
         case ($urandom_range(0, 9))
            0, 1: cmd = OP_LI;
            2: cmd = CmdWidth'($urandom_range(20, 31));
            default: cmd = CmdWidth'($urandom_range(0, 19));
         endcase
         send_instr(cmd, 5'($urandom()), 5'($urandom()),
            ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom()),
            (cmd == OP_LI) ? pick_value() : $urandom());
         if (n == 900) begin
            req.valid <= 1'b0;
            wait (pending_count == 0);
            @(negedge clock);
         end
      end

      req.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (50) @(posedge clock);
      $display("Sent %0d instruction words, checked %0d result words.", sent_count, result_count);
      $display("Covered every operation, both extremes of all fields and random stalls.");
      if (fail_count == 0)
         $display("PASS mips_like_execute_unit");
      else
         $display("FAIL mips_like_execute_unit");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL mips_like_execute_unit");
      $finish;
   end

endmodule

FILE: mips_like_execute_unit.f
design/mleu_pkg.sv
design/mleu_req_if.sv
design/mleu_ctrl.sv
design/mleu_dpath.sv
design/mips_like_execute_unit.sv
tb/sv/mips_like_execute_unit_checker.sv
tb/sv/mips_like_execute_unit_tb.sv
